>>> rtl/core/jsu_pkg.sv
// Shared types, codes and constants for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Error causes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN      = 4'd1;
    localparam logic [3:0] ERR_ESC_END      = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_BAD_LOW_HEX  = 4'd4;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd5;
    localparam logic [3:0] ERR_NO_PAIR      = 4'd6;
    localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd7;
    localparam logic [3:0] ERR_CONTROL      = 4'd8;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

    // Code point width and the base of the supplementary planes
    localparam int          CP_W      = 21;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Default depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One request from the front: a raw byte, a code point, a completion or an error
    typedef struct packed {
        kind_t             kind;
        logic [3:0]        err;
        logic              raw;
        logic [CP_W-1:0]   cp;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/jsu_front.sv
// Front end: accepts text bytes, tracks the string syntax and issues requests.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] text_byte,
    input  wire logic       byte_present,
    input  wire logic       push,
    output logic            full,
    output logic            cmd_push,
    output cmd_t            cmd_data,
    input  wire logic       cmd_full
);

    typedef enum logic [6:0] {
        M_IDLE = 7'b0000001,
        M_STR  = 7'b0000010,
        M_ESC  = 7'b0000100,
        M_HEX  = 7'b0001000,
        M_PBS  = 7'b0010000,
        M_PU   = 7'b0100000,
        M_LHEX = 7'b1000000
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [5:0] HI_TAG   = 6'b110110;
    localparam logic [5:0] LO_TAG   = 6'b110111;

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] high_reg, high_next;

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] hex_word;

    // Decode one hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    assign {hex_ok, hex_digit} = byte_present ? hex_value(text_byte) : 5'd0;
    assign hex_word            = {hex_accum_reg[11:0], hex_digit};

    // Advance the syntax state and form the request for this byte
    always_comb
    begin
        mode_next      = mode_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        high_next      = high_reg;
        cmd_push       = 1'b0;
        cmd_data.kind  = KIND_DATA;
        cmd_data.err   = ERR_NONE;
        cmd_data.raw   = 1'b1;
        cmd_data.cp    = {13'd0, text_byte};

        if (accept)
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    if (byte_present && text_byte == CH_QUOTE)
                        mode_next = M_STR;
                    else
                    begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = ERR_NO_OPEN;
                    end
                end
                M_STR:
                begin
                    cmd_push = 1'b1;
                    priority if (!byte_present)
                    begin
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = ERR_UNTERMINATED;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_DONE;
                    end
                    else if (text_byte == CH_BSL)
                    begin
                        mode_next = M_ESC;
                        cmd_push  = 1'b0;
                    end
                    else if (text_byte < CH_SPACE)
                    begin
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = ERR_CONTROL;
                    end
                    else
                        cmd_data.kind = KIND_DATA;
                end
                M_ESC:
                begin
                    cmd_push  = 1'b1;
                    mode_next = M_STR;
                    if (!byte_present)
                    begin
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = ERR_ESC_END;
                    end
                    else
                    begin
                        unique case (text_byte)
                            CH_QUOTE, CH_BSL, CH_SLASH: cmd_data.cp = {13'd0, text_byte};
                            CH_B: cmd_data.cp = 21'h08;
                            CH_F: cmd_data.cp = 21'h0C;
                            CH_N: cmd_data.cp = 21'h0A;
                            CH_R: cmd_data.cp = 21'h0D;
                            CH_T: cmd_data.cp = 21'h09;
                            CH_U:
                            begin
                                cmd_push       = 1'b0;
                                mode_next      = M_HEX;
                                hex_accum_next = 16'd0;
                                hex_count_next = 2'd0;
                            end
                            default:
                            begin
                                mode_next     = M_IDLE;
                                cmd_data.kind = KIND_ERR;
                                cmd_data.err  = ERR_UNKNOWN_ESC;
                            end
                        endcase
                    end
                end
                M_HEX, M_LHEX:
                begin
                    priority if (!hex_ok)
                    begin
                        cmd_push      = 1'b1;
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = (mode_reg == M_HEX) ? ERR_BAD_HEX : ERR_BAD_LOW_HEX;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_accum_next = hex_word;
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        hex_accum_next = 16'd0;
                        hex_count_next = 2'd0;
                        cmd_data.raw   = 1'b0;
                        priority if (mode_reg == M_HEX && hex_word[15:10] == HI_TAG)
                        begin
                            high_next = hex_word;
                            mode_next = M_PBS;
                        end
                        else if (mode_reg == M_HEX)
                        begin
                            cmd_push    = 1'b1;
                            mode_next   = M_STR;
                            cmd_data.cp = {5'd0, hex_word};
                        end
                        else if (hex_word[15:10] != LO_TAG)
                        begin
                            cmd_push      = 1'b1;
                            mode_next     = M_IDLE;
                            cmd_data.kind = KIND_ERR;
                            cmd_data.err  = ERR_BAD_LOW;
                        end
                        else
                        begin
                            // Join the pair into one supplementary code point
                            cmd_push    = 1'b1;
                            mode_next   = M_STR;
                            cmd_data.cp = SUPP_BASE + {1'b0, high_reg[9:0], hex_word[9:0]};
                        end
                    end
                end
                M_PBS, M_PU:
                begin
                    if (byte_present && mode_reg == M_PBS && text_byte == CH_BSL)
                        mode_next = M_PU;
                    else if (byte_present && mode_reg == M_PU && text_byte == CH_U)
                    begin
                        mode_next      = M_LHEX;
                        hex_accum_next = 16'd0;
                        hex_count_next = 2'd0;
                    end
                    else
                    begin
                        cmd_push      = 1'b1;
                        mode_next     = M_IDLE;
                        cmd_data.kind = KIND_ERR;
                        cmd_data.err  = ERR_NO_PAIR;
                    end
                end
                default:
                    mode_next = M_IDLE;
            endcase
        end

        // Non-data requests carry no byte
        if (cmd_data.kind != KIND_DATA)
        begin
            cmd_data.raw = 1'b1;
            cmd_data.cp  = '0;
        end
    end

    // Hold the syntax state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            hex_accum_reg <= 16'd0;
            hex_count_reg <= 2'd0;
            high_reg      <= 16'd0;
        end
        else
        begin
            mode_reg      <= mode_next;
            hex_accum_reg <= hex_accum_next;
            hex_count_reg <= hex_count_next;
            high_reg      <= high_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_cmd_fifo.sv
// Request queue between the front end and the byte emitter.
`default_nettype none

module jsu_cmd_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("request written into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue occupancy did not grow on write");

endmodule

`default_nettype wire

>>> rtl/core/jsu_back.sv
// Back end: turns queued requests into UTF-8 bytes, completions and errors.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd_data,
    input  wire logic       cmd_empty,
    output logic            cmd_pop,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [3:0]      error_code,
    output logic            last_of_run,
    output logic            empty,
    input  wire logic       pop
);

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last;
    } enc_t;

    // Encode one request into up to four bytes
    function automatic enc_t encode(input cmd_t c);
        enc_t e;
        e.bytes = '0;
        e.last  = 2'd0;
        if (c.kind == KIND_DATA)
        begin
            priority if (c.raw || c.cp[20:7] == '0)
                e.bytes[0] = c.cp[7:0];
            else if (c.cp[20:11] == '0)
            begin
                e.bytes[0] = {3'b110, c.cp[10:6]};
                e.bytes[1] = {2'b10, c.cp[5:0]};
                e.last     = 2'd1;
            end
            else if (c.cp[20:16] == '0)
            begin
                e.bytes[0] = {4'b1110, c.cp[15:12]};
                e.bytes[1] = {2'b10, c.cp[11:6]};
                e.bytes[2] = {2'b10, c.cp[5:0]};
                e.last     = 2'd2;
            end
            else
            begin
                e.bytes[0] = {5'b11110, c.cp[20:18]};
                e.bytes[1] = {2'b10, c.cp[17:12]};
                e.bytes[2] = {2'b10, c.cp[11:6]};
                e.bytes[3] = {2'b10, c.cp[5:0]};
                e.last     = 2'd3;
            end
        end
        return e;
    endfunction

    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic [1:0]      last_reg;
    logic [3:0][7:0] bytes_reg;
    kind_t           kind_reg;
    logic [3:0]      err_reg;
    enc_t            enc;
    logic            at_last;
    logic            take;

    assign enc     = encode(cmd_data);
    assign at_last = (idx_reg == last_reg);
    assign take    = pop && busy_reg;
    assign cmd_pop = !cmd_empty && (!busy_reg || (take && at_last));

    assign empty       = !busy_reg;
    assign out_byte    = bytes_reg[idx_reg];
    assign kind        = kind_reg;
    assign error_code  = err_reg;
    assign last_of_run = at_last;

    // Load the next request or step through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            last_reg <= 2'd0;
        end
        else if (cmd_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
            last_reg <= enc.last;
        end
        else if (take)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the payload of the current request
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            bytes_reg <= enc.bytes;
            kind_reg  <= cmd_data.kind;
            err_reg   <= cmd_data.err;
        end
    end

    a_single_non_data: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && kind_reg != KIND_DATA) |-> (last_reg == 2'd0))
        else $error("completion or error spans several results");

    a_non_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && kind_reg != KIND_DATA) |-> (out_byte == 8'd0 && idx_reg == 2'd0))
        else $error("completion or error carries a byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_reg))
        else $error("byte index past end of request");

endmodule

`default_nettype wire

>>> rtl/core/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output.
// The first result of an input byte is written into the request queue and then loaded into the
// back end's payload registers before it is on the outputs; it waits while the emitter is busy.
// Throughput: one input byte per cycle while the queue is not full; a \u code point yields 1 to 4
// results, emitted one per cycle while pop is high, by the single byte emitter in the back end.
// The request queue (DEPTH entries) lets input run ahead while output stalls.
// Reset (rst_n low, asynchronous): idle awaiting an opening quote, queue empty.
`default_nettype none

module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] text_byte,
    input  wire logic       byte_present,
    input  wire logic       push,
    output logic            full,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [3:0]      error_code,
    output logic            last_of_run,
    output logic            empty,
    input  wire logic       pop
);

    cmd_t wr_cmd;
    cmd_t rd_cmd;
    logic wr_en;
    logic q_full;
    logic q_empty;
    logic rd_en;

    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .push         (push),
        .full         (full),
        .cmd_push     (wr_en),
        .cmd_data     (wr_cmd),
        .cmd_full     (q_full)
    );

    jsu_cmd_fifo #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd_en   (rd_en),
        .rd_data (rd_cmd),
        .empty   (q_empty)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_data    (rd_cmd),
        .cmd_empty   (q_empty),
        .cmd_pop     (rd_en),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire
